@@ rtl/shp_pkg.sv @@
package shp_pkg;

  localparam int MAX_CRED_BYTES = 8;
  localparam int MAX_FIELD_LEN  = 127;

  localparam int CRED_W   = 64;
  localparam int CLEN_W   = 4;
  localparam int FIDX_W   = $clog2(MAX_CRED_BYTES + 1);
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_USER_BYTES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USER_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PASS_BYTES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PASS_LENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_NOAUTH = 3'd4;

  // reply kinds
  localparam logic [1:0] KIND_METHOD  = 2'd0;
  localparam logic [1:0] KIND_AUTH_OK = 2'd1;
  localparam logic [1:0] KIND_CONNECT = 2'd2;
  localparam logic [1:0] KIND_REJECT  = 2'd3;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_VERSION   = 3'd1;
  localparam logic [2:0] ERR_NO_METHOD = 3'd2;
  localparam logic [2:0] ERR_AUTH_FMT  = 3'd3;
  localparam logic [2:0] ERR_CRED      = 3'd4;
  localparam logic [2:0] ERR_COMMAND   = 3'd5;
  localparam logic [2:0] ERR_ATYP      = 3'd6;

  // wire values
  localparam logic [7:0] SOCKS_VER     = 8'h05;
  localparam logic [7:0] AUTH_VER      = 8'h01;
  localparam logic [7:0] REQ_CONNECT   = 8'h01;
  localparam logic [7:0] ADDR_V4       = 8'h01;
  localparam logic [7:0] METH_NO_AUTH  = 8'h00;
  localparam logic [7:0] METH_USERPASS = 8'h02;
  localparam logic [7:0] METH_NONE     = 8'hFF;
  localparam logic [7:0] FIELD_LEN_MAX = 8'(MAX_FIELD_LEN);

  typedef enum logic [14:0] {
    PH_VER      = 15'b000000000000001,
    PH_NMETH    = 15'b000000000000010,
    PH_METHODS  = 15'b000000000000100,
    PH_AUTH_VER = 15'b000000000001000,
    PH_ULEN     = 15'b000000000010000,
    PH_UNAME    = 15'b000000000100000,
    PH_PLEN     = 15'b000000001000000,
    PH_PASS     = 15'b000000010000000,
    PH_REQ_VER  = 15'b000000100000000,
    PH_REQ_CMD  = 15'b000001000000000,
    PH_REQ_RSV  = 15'b000010000000000,
    PH_REQ_ATYP = 15'b000100000000000,
    PH_ADDR     = 15'b001000000000000,
    PH_PORT     = 15'b010000000000000,
    PH_IDLE     = 15'b100000000000000
  } phase_t;

  typedef struct packed {
    logic [CRED_W-1:0] user_bytes;
    logic [CLEN_W-1:0] user_length;
    logic [CRED_W-1:0] pass_bytes;
    logic [CLEN_W-1:0] pass_length;
    logic              noauth_en;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [7:0]  method;
    logic [31:0] ip;
    logic [15:0] port;
    logic [2:0]  err;
  } res_t;

endpackage

@@ rtl/shp_cred_match.sv @@
module shp_cred_match (
  input  logic [7:0]                  rx_byte,
  input  logic [shp_pkg::CRED_W-1:0]  cred_bytes,
  input  logic [shp_pkg::CLEN_W-1:0]  cred_len,
  input  logic [shp_pkg::FIDX_W-1:0]  idx,
  output logic                        hit
);
  import shp_pkg::*;

  logic [CLEN_W-1:0] pos;
  logic              in_range;
  logic [7:0]        exp_byte;

  // first byte sits highest, so byte idx lives at position len-1-idx
  assign pos      = cred_len - CLEN_W'(1) - CLEN_W'(idx);
  assign in_range = (cred_len <= CLEN_W'(MAX_CRED_BYTES)) && (CLEN_W'(idx) < cred_len);
  assign exp_byte = cred_bytes[{pos[2:0], 3'b000} +: 8];
  assign hit      = in_range && (exp_byte == rx_byte);

endmodule

@@ rtl/shp_parser.sv @@
module shp_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic [7:0]    rx_byte,
  input  logic          session_start,
  input  shp_pkg::cfg_t cfg,
  output shp_pkg::res_t res
);
  import shp_pkg::*;

  phase_t             phase_r, phase_nxt, ph;
  logic [7:0]         bytes_left_r, bytes_left_nxt, bl, bl_dec;
  logic [7:0]         chosen_r, chosen_nxt, cm;
  logic [FIDX_W-1:0]  fidx_r, fidx_nxt, fi, fi_inc;
  logic               match_r, match_nxt, ms;
  logic [31:0]        addr_r, addr_nxt, ad;
  logic [15:0]        port_r, port_nxt, pt;
  logic               use_pass;
  logic [CRED_W-1:0]  cred_bytes;
  logic [CLEN_W-1:0]  cred_len;
  logic               cred_hit;
  logic               start_ok;

  assign use_pass   = (ph == PH_PASS) || (ph == PH_PLEN);
  assign cred_bytes = use_pass ? cfg.pass_bytes : cfg.user_bytes;
  assign cred_len   = use_pass ? cfg.pass_length : cfg.user_length;
  assign start_ok   = (cred_len <= CLEN_W'(MAX_CRED_BYTES)) && (CLEN_W'(rx_byte) == cred_len)
                      && (rx_byte[7:CLEN_W] == '0);

  shp_cred_match u_cred (
    .rx_byte    (rx_byte),
    .cred_bytes (cred_bytes),
    .cred_len   (cred_len),
    .idx        (fi),
    .hit        (cred_hit)
  );

  // session start restarts the parser before this byte is looked at
  always_comb begin
    ph = session_start ? PH_VER : phase_r;
    bl = session_start ? 8'd0 : bytes_left_r;
    cm = session_start ? METH_NONE : chosen_r;
    fi = session_start ? '0 : fidx_r;
    ms = session_start ? 1'b1 : match_r;
    ad = session_start ? 32'd0 : addr_r;
    pt = session_start ? 16'd0 : port_r;
  end

  assign bl_dec = bl - 8'd1;
  // index only matters while below the credential length, so it saturates
  assign fi_inc = (fi == FIDX_W'(MAX_CRED_BYTES)) ? fi : fi + FIDX_W'(1);

  always_comb begin
    phase_nxt      = ph;
    bytes_left_nxt = bl;
    chosen_nxt     = cm;
    fidx_nxt       = fi;
    match_nxt      = ms;
    addr_nxt       = ad;
    port_nxt       = pt;
    res            = '0;
    case (ph)
      PH_VER: begin
        if (rx_byte != SOCKS_VER) begin
          phase_nxt = PH_IDLE;
          res.valid = 1'b1; res.kind = KIND_REJECT; res.err = ERR_VERSION;
        end else begin
          phase_nxt = PH_NMETH;
        end
      end
      PH_NMETH: begin
        chosen_nxt     = METH_NONE;
        bytes_left_nxt = rx_byte;
        if (rx_byte == 8'd0) begin
          phase_nxt = PH_IDLE;
          res.valid = 1'b1; res.kind = KIND_REJECT;
          res.method = METH_NONE; res.err = ERR_NO_METHOD;
        end else begin
          phase_nxt = PH_METHODS;
        end
      end
      PH_METHODS: begin
        if (rx_byte == METH_NO_AUTH && cfg.noauth_en) chosen_nxt = METH_NO_AUTH;
        if (rx_byte == METH_USERPASS) chosen_nxt = METH_USERPASS;
        bytes_left_nxt = bl_dec;
        if (bl_dec == 8'd0) begin
          res.valid = 1'b1;
          if (chosen_nxt == METH_NONE) begin
            phase_nxt = PH_IDLE;
            res.kind = KIND_REJECT; res.method = METH_NONE; res.err = ERR_NO_METHOD;
          end else begin
            phase_nxt  = (chosen_nxt == METH_USERPASS) ? PH_AUTH_VER : PH_REQ_VER;
            res.kind   = KIND_METHOD;
            res.method = chosen_nxt;
          end
        end
      end
      PH_AUTH_VER: begin
        if (rx_byte != AUTH_VER) begin
          phase_nxt = PH_IDLE;
          res.valid = 1'b1; res.kind = KIND_REJECT; res.err = ERR_AUTH_FMT;
        end else begin
          phase_nxt = PH_ULEN;
        end
      end
      PH_ULEN, PH_PLEN: begin
        if (rx_byte > FIELD_LEN_MAX) begin
          phase_nxt = PH_IDLE;
          res.valid = 1'b1; res.kind = KIND_REJECT; res.err = ERR_AUTH_FMT;
        end else begin
          bytes_left_nxt = rx_byte;
          fidx_nxt       = '0;
          match_nxt      = start_ok;
          if (rx_byte == 8'd0) begin
            // empty string is judged on its length byte
            if (!start_ok) begin
              phase_nxt = PH_IDLE;
              res.valid = 1'b1; res.kind = KIND_REJECT; res.err = ERR_CRED;
            end else if (ph == PH_ULEN) begin
              phase_nxt = PH_PLEN;
            end else begin
              phase_nxt = PH_REQ_VER;
              res.valid = 1'b1; res.kind = KIND_AUTH_OK;
            end
          end else begin
            phase_nxt = (ph == PH_ULEN) ? PH_UNAME : PH_PASS;
          end
        end
      end
      PH_UNAME, PH_PASS: begin
        match_nxt      = ms && cred_hit;
        fidx_nxt       = fi_inc;
        bytes_left_nxt = bl_dec;
        if (bl_dec == 8'd0) begin
          if (!(ms && cred_hit)) begin
            phase_nxt = PH_IDLE;
            res.valid = 1'b1; res.kind = KIND_REJECT; res.err = ERR_CRED;
          end else if (ph == PH_UNAME) begin
            phase_nxt = PH_PLEN;
          end else begin
            phase_nxt = PH_REQ_VER;
            res.valid = 1'b1; res.kind = KIND_AUTH_OK;
          end
        end
      end
      PH_REQ_VER: begin
        if (rx_byte != SOCKS_VER) begin
          phase_nxt = PH_IDLE;
          res.valid = 1'b1; res.kind = KIND_REJECT; res.err = ERR_VERSION;
        end else begin
          phase_nxt = PH_REQ_CMD;
        end
      end
      PH_REQ_CMD: begin
        if (rx_byte != REQ_CONNECT) begin
          phase_nxt = PH_IDLE;
          res.valid = 1'b1; res.kind = KIND_REJECT; res.err = ERR_COMMAND;
        end else begin
          phase_nxt = PH_REQ_RSV;
        end
      end
      PH_REQ_RSV: begin
        if (rx_byte != 8'd0) begin
          phase_nxt = PH_IDLE;
          res.valid = 1'b1; res.kind = KIND_REJECT; res.err = ERR_COMMAND;
        end else begin
          phase_nxt = PH_REQ_ATYP;
        end
      end
      PH_REQ_ATYP: begin
        if (rx_byte != ADDR_V4) begin
          phase_nxt = PH_IDLE;
          res.valid = 1'b1; res.kind = KIND_REJECT; res.err = ERR_ATYP;
        end else begin
          addr_nxt       = 32'd0;
          port_nxt       = 16'd0;
          bytes_left_nxt = 8'd4;
          phase_nxt      = PH_ADDR;
        end
      end
      PH_ADDR: begin
        addr_nxt       = {ad[23:0], rx_byte};
        bytes_left_nxt = bl_dec;
        if (bl_dec == 8'd0) begin
          bytes_left_nxt = 8'd2;
          phase_nxt      = PH_PORT;
        end
      end
      PH_PORT: begin
        port_nxt       = {pt[7:0], rx_byte};
        bytes_left_nxt = bl_dec;
        if (bl_dec == 8'd0) begin
          phase_nxt = PH_IDLE;
          res.valid = 1'b1; res.kind = KIND_CONNECT;
          res.ip    = ad;   res.port = {pt[7:0], rx_byte};
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_VER;
      bytes_left_r <= 8'd0;
      chosen_r     <= METH_NONE;
      fidx_r       <= '0;
      match_r      <= 1'b1;
      addr_r       <= 32'd0;
      port_r       <= 16'd0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      chosen_r     <= chosen_nxt;
      fidx_r       <= fidx_nxt;
      match_r      <= match_nxt;
      addr_r       <= addr_nxt;
      port_r       <= port_nxt;
    end
  end

endmodule

@@ rtl/socks5_handshake_parser.sv @@
// an accepted byte sits in the input register, then its result lands in the result register
// and is offered on the out_ side from there
// throughput: one byte per cycle; the input side only stalls while a result
// waits in the result register and out_tready is low
// reset: rst_n low at a clock edge clears the parser to wait for a greeting,
// empties both registers and clears all configuration registers to zero
module socks5_handshake_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,  // rx_byte
  input  logic [0:0]                     in_tuser,  // session_start
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [63:0]                    out_tdata, // reply_method, dest_ip, dest_port, error_code
  output logic [1:0]                     out_tuser, // reply_kind
  input  logic                           cfg_we,
  input  logic [shp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [shp_pkg::CRED_W-1:0]     cfg_data
);
  import shp_pkg::*;

  cfg_t        cfg_r;
  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_start_r;
  logic        step;
  res_t        res;
  res_t        out_r;

  // a byte is processed when the result slot is free or being drained
  assign step      = in_valid_r && (!out_r.valid || out_tready);
  assign in_tready = !in_valid_r || step;

  shp_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .rx_byte       (in_byte_r),
    .session_start (in_start_r),
    .cfg           (cfg_r),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_USER_BYTES:   cfg_r.user_bytes    <= cfg_data;
        REG_USER_LENGTH:  cfg_r.user_length   <= cfg_data[CLEN_W-1:0];
        REG_PASS_BYTES:   cfg_r.pass_bytes    <= cfg_data;
        REG_PASS_LENGTH:  cfg_r.pass_length   <= cfg_data[CLEN_W-1:0];
        REG_ALLOW_NOAUTH: cfg_r.noauth_en     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r  <= in_tdata;
      in_start_r <= in_tuser[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (step && res.valid) begin
      out_r.valid <= 1'b1;
    end else if (out_tready) begin
      out_r.valid <= 1'b0;
    end
    if (step && res.valid) begin
      out_r.kind   <= res.kind;
      out_r.method <= res.method;
      out_r.ip     <= res.ip;
      out_r.port   <= res.port;
      out_r.err    <= res.err;
    end
  end

  assign out_tvalid = out_r.valid;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {5'd0, out_r.err, out_r.port, out_r.ip, out_r.method};

endmodule

@@ rtl/shp_checker.sv @@
module shp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import shp_pkg::*;

  // a held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_reject_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_REJECT |-> out_tdata[58:56] != ERR_NONE)
    else $error("reject without error code");

  a_ok_no_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_REJECT |-> out_tdata[58:56] == ERR_NONE)
    else $error("error code on a non-reject result");

  a_addr_only_connect: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_CONNECT |-> out_tdata[55:8] == 48'd0)
    else $error("address or port on a non-connect result");

endmodule

bind socks5_handshake_parser shp_checker u_shp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
